// ----- rtl/core/ramst_pkg.sv -----
// Shared types and constants for the range-assign, range-minimum segment tree.
// No dependencies.
`timescale 1ns / 1ps

package ramst_pkg;

    localparam int FIELD_BITS = 10;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ASSIGN = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

endpackage

// ----- rtl/core/range_assign_min_segment_tree_unit.sv -----
// Range-assign, range-minimum segment tree with lazy pending marks, top level.
// Depends on ramst_pkg.
//
// Command-style unit: a transaction is taken when start is high and busy is low, and a
// query result shows on o_range_minimum for one cycle with o_valid; the receiver cannot
// stall it. After reset the node memory is cleared, one node per cycle, all 2*LEAF_COUNT
// entries, with busy high. One walker steps the tree in depth-first order through a
// node memory with one read port, one write port and a registered read. Each visited
// node passes through read, evaluate and finish states, plus left and right push states
// when a pending mark is pushed down; the finish step of a right child climbs to its
// parent. An assign or query visits at most about 4*log2(LEAF_COUNT) nodes, and a load
// visits 2*log2(LEAF_COUNT)+1 nodes. An assign or query over an empty range, or an
// unknown command, is taken without busy ever rising.
module range_assign_min_segment_tree_unit #(
    parameter int LEAF_COUNT = 1024,
    parameter int VALUE_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_command,
    input  logic [ramst_pkg::FIELD_BITS-1:0] i_leaf_index,
    input  logic [ramst_pkg::FIELD_BITS-1:0] i_range_low,
    input  logic [ramst_pkg::FIELD_BITS-1:0] i_range_high,
    input  logic [ramst_pkg::FIELD_BITS-1:0] i_fill_value,
    output logic                             o_valid,
    output logic [ramst_pkg::FIELD_BITS-1:0] o_range_minimum
);

    localparam int LOG   = $clog2(LEAF_COUNT);
    localparam int AW    = LOG + 1;
    localparam int DW    = $clog2(LOG + 1);
    localparam int FB    = ramst_pkg::FIELD_BITS;
    localparam int CW    = (LOG > FB) ? LOG : FB;
    localparam int VB    = VALUE_BITS;
    localparam int WW    = 2 * VB + 1;
    localparam int DEPTH = 2 * LEAF_COUNT;

    localparam logic [CW-1:0]  LAST_C    = CW'(LEAF_COUNT - 1);
    localparam logic [DW-1:0]  LOG_D     = DW'(LOG);
    localparam logic [DW-1:0]  LOG_M1_D  = DW'(LOG - 1);
    localparam logic [AW-1:0]  CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [AW-1:0]  ROOT      = AW'(1);
    localparam logic [LOG-1:0] SPAN_MASK = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_PUSHL,
        S_PUSHR,
        S_FIN
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_clr;
    ramst_pkg::t_cmd      r_cmd;
    logic [LOG-1:0]       r_lo;
    logic [LOG-1:0]       r_hi;
    logic [VB-1:0]        r_val;
    logic [AW-1:0]        r_node;
    logic [DW-1:0]        r_depth;
    logic [VB-1:0]        r_fmin;
    logic [VB-1:0]        r_acc;
    logic [VB-1:0]        r_pend;
    logic [VB-1:0]        r_lm [LOG+1];
    logic [WW-1:0]        r_q;
    logic                 r_valid;
    logic [FB-1:0]        r_out;

    logic [WW-1:0]        mem [DEPTH];
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [WW-1:0]        mem_wd;

    // input decode
    logic [CW-1:0]        c_lo;
    logic [CW-1:0]        c_hi;
    logic [CW-1:0]        c_hi_sat;
    logic [CW-1:0]        c_idx;
    logic                 in_empty;

    // node evaluation
    logic [AW-1:0]        node_sh;
    logic [LOG-1:0]       node_lo;
    logic [LOG-1:0]       node_hi;
    logic                 disjoint;
    logic                 covered;
    logic                 internal;
    logic                 is_query;
    logic [VB-1:0]        q_min;
    logic [VB-1:0]        q_pval;
    logic                 q_pv;
    logic [VB-1:0]        fmin_up;
    logic [VB-1:0]        lm_cur;
    logic                 child_int;

    assign c_lo     = CW'(i_range_low);
    assign c_hi     = CW'(i_range_high);
    assign c_hi_sat = (c_hi > LAST_C) ? LAST_C : c_hi;
    assign c_idx    = CW'(i_leaf_index) & LAST_C;
    assign in_empty = (c_lo > LAST_C) || (c_lo > c_hi_sat);

    assign node_sh   = r_node << (LOG_D - r_depth);
    assign node_lo   = node_sh[LOG-1:0];
    assign node_hi   = node_lo | (SPAN_MASK >> r_depth);
    assign disjoint  = (r_hi < node_lo) || (node_hi < r_lo);
    assign covered   = (r_lo <= node_lo) && (node_hi <= r_hi);
    assign internal  = !r_node[LOG];
    assign is_query  = (r_cmd == ramst_pkg::CMD_QUERY);
    assign q_min     = r_q[WW-1:VB+1];
    assign q_pval    = r_q[VB:1];
    assign q_pv      = r_q[0];
    assign lm_cur    = r_lm[r_depth];
    assign fmin_up   = (lm_cur < r_fmin) ? lm_cur : r_fmin;
    assign child_int = (r_depth < LOG_M1_D);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_node;
        mem_wd = {{VB{1'b1}}, {VB{1'b0}}, 1'b0};
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            S_EVAL: begin
                if (!is_query && !disjoint) begin
                    if (covered) begin
                        mem_we = 1'b1;
                        mem_wd = {r_val, r_val, internal};
                    end else if (q_pv) begin
                        mem_we = 1'b1;
                        mem_wd = {q_min, q_pval, 1'b0};
                    end
                end
            end
            S_PUSHL: begin
                mem_we = 1'b1;
                mem_wa = {r_node[AW-2:0], 1'b0};
                mem_wd = {r_pend, r_pend, child_int};
            end
            S_PUSHR: begin
                mem_we = 1'b1;
                mem_wa = {r_node[AW-2:0], 1'b1};
                mem_wd = {r_pend, r_pend, child_int};
            end
            S_FIN: begin
                if (!is_query && r_node != ROOT && r_node[0]) begin
                    mem_we = 1'b1;
                    mem_wa = r_node >> 1;
                    mem_wd = {fmin_up, {VB{1'b0}}, 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_q <= mem[r_node];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= ramst_pkg::t_cmd'(i_command);
                        r_val   <= VB'(i_fill_value);
                        r_node  <= ROOT;
                        r_depth <= '0;
                        r_acc   <= '1;
                        unique case (i_command)
                            ramst_pkg::CMD_LOAD: begin
                                r_lo    <= c_idx[LOG-1:0];
                                r_hi    <= c_idx[LOG-1:0];
                                r_state <= S_RD;
                            end
                            ramst_pkg::CMD_ASSIGN: begin
                                r_lo <= c_lo[LOG-1:0];
                                r_hi <= c_hi_sat[LOG-1:0];
                                if (!in_empty) begin
                                    r_state <= S_RD;
                                end
                            end
                            ramst_pkg::CMD_QUERY: begin
                                r_lo <= c_lo[LOG-1:0];
                                r_hi <= c_hi_sat[LOG-1:0];
                                if (in_empty) begin
                                    r_valid <= 1'b1;
                                    r_out   <= FB'({VB{1'b1}});
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    priority if (disjoint) begin
                        r_fmin  <= q_min;
                        r_state <= S_FIN;
                    end else if (covered) begin
                        r_fmin  <= is_query ? q_min : r_val;
                        if (q_min < r_acc) begin
                            r_acc <= q_min;
                        end
                        r_state <= S_FIN;
                    end else if (q_pv) begin
                        if (is_query) begin
                            if (q_pval < r_acc) begin
                                r_acc <= q_pval;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_pend  <= q_pval;
                            r_state <= S_PUSHL;
                        end
                    end else begin
                        r_node  <= r_node << 1;
                        r_depth <= r_depth + DW'(1);
                        r_state <= S_RD;
                    end
                end
                S_PUSHL: begin
                    r_state <= S_PUSHR;
                end
                S_PUSHR: begin
                    r_node  <= r_node << 1;
                    r_depth <= r_depth + DW'(1);
                    r_state <= S_RD;
                end
                S_FIN: begin
                    priority if (r_node == ROOT) begin
                        if (is_query) begin
                            r_valid <= 1'b1;
                            r_out   <= FB'(r_acc);
                        end
                        r_state <= S_IDLE;
                    end else if (!r_node[0]) begin
                        r_lm[r_depth] <= r_fmin;
                        r_node        <= r_node + AW'(1);
                        r_state       <= S_RD;
                    end else begin
                        r_node  <= r_node >> 1;
                        r_depth <= r_depth - DW'(1);
                        r_fmin  <= fmin_up;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_range_minimum = r_out;

    a_node_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ((r_node >> r_depth) == ROOT))
        else $error("walker node does not match its depth");

    a_query_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR && r_state != S_IDLE && is_query) |-> !mem_we)
        else $error("node memory written during a query");

    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_node == ROOT && is_query) |=> o_valid)
        else $error("query finished without a result");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSHR) |-> ($past(r_state) == S_PUSHL))
        else $error("right push without left push");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for range_assign_min_segment_tree_unit: a directed table, then
// random load/assign/query and unknown-command traffic, checked against an in-bench lazy segment tree model.
// Depends on ramst_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;

    localparam int LEAVES = 1024;
    localparam int VBITS  = 10;
    localparam logic [VBITS-1:0] EMPTY = '1;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [1:0] cmd;
        logic [9:0] leaf;
        logic [9:0] lo;
        logic [9:0] hi;
        logic [9:0] fill;
        bit         known;
        logic [9:0] result;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_command;
    logic [9:0] i_leaf_index;
    logic [9:0] i_range_low;
    logic [9:0] i_range_high;
    logic [9:0] i_fill_value;
    logic       o_valid;
    logic [9:0] o_range_minimum;

    logic [VBITS-1:0] tree_min [1:2*LEAVES-1];
    logic [VBITS-1:0] mark_val [1:LEAVES-1];
    bit               mark_on  [1:LEAVES-1];

    logic [9:0] minimum_queue[$];
    int         fail_count;
    int         idle_cycles;
    t_row       rows[$];

    range_assign_min_segment_tree_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_leaf_index   (i_leaf_index),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_fill_value   (i_fill_value),
        .o_valid        (o_valid),
        .o_range_minimum(o_range_minimum)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_mark(int n);
        if (!mark_on[n]) return;
        for (int c = 2 * n; c <= 2 * n + 1; c++) begin
            tree_min[c] = mark_val[n];
            if (c < LEAVES) begin
                mark_val[c] = mark_val[n];
                mark_on[c]  = 1'b1;
            end
        end
        mark_on[n] = 1'b0;
    endfunction

    function automatic void tree_assign(int n, int lo, int hi, int l, int r,
                                        logic [VBITS-1:0] v);
        int mid;
        if (r < lo || hi < l) return;
        if (l <= lo && hi <= r) begin
            tree_min[n] = v;
            if (n < LEAVES) begin
                mark_val[n] = v;
                mark_on[n]  = 1'b1;
            end
            return;
        end
        push_mark(n);
        mid = lo + (hi - lo) / 2;
        tree_assign(2 * n, lo, mid, l, r, v);
        tree_assign(2 * n + 1, mid + 1, hi, l, r, v);
        tree_min[n] = (tree_min[2*n] < tree_min[2*n+1]) ? tree_min[2*n] : tree_min[2*n+1];
    endfunction

    function automatic logic [VBITS-1:0] tree_min_over(int n, int lo, int hi, int l, int r);
        int mid;
        logic [VBITS-1:0] a, b;
        if (r < lo || hi < l) return EMPTY;
        if (l <= lo && hi <= r) return tree_min[n];
        if (mark_on[n]) return mark_val[n];
        mid = lo + (hi - lo) / 2;
        a = tree_min_over(2 * n, lo, mid, l, r);
        b = tree_min_over(2 * n + 1, mid + 1, hi, l, r);
        return (a < b) ? a : b;
    endfunction

    // Apply one transaction to the model; queue the minimum a query returns.
    function automatic void apply_command(t_row t);
        int lo, hi;
        logic [9:0] m;
        lo = t.lo;
        hi = (t.hi > LEAVES - 1) ? LEAVES - 1 : t.hi;
        case (t.cmd)
            ramst_pkg::CMD_LOAD:
                tree_assign(1, 0, LEAVES - 1, t.leaf, t.leaf, t.fill);
            ramst_pkg::CMD_ASSIGN:
                if (lo <= hi) tree_assign(1, 0, LEAVES - 1, lo, hi, t.fill);
            ramst_pkg::CMD_QUERY: begin
                m = (lo > hi) ? EMPTY : tree_min_over(1, 0, LEAVES - 1, lo, hi);
                if (t.known && m !== t.result) begin
                    $display("%0t table mismatch: expected %0d actual %0d", $time, t.result, m);
                    fail_count++;
                end
                minimum_queue.push_back(m);
            end
            default: ;
        endcase
    endfunction

    function automatic t_row mk(logic [1:0] c, int leaf, int lo, int hi, int fill,
                                bit known = 0, int res = 0);
        t_row t;
        t.cmd = c; t.leaf = 10'(leaf); t.lo = 10'(lo); t.hi = 10'(hi); t.fill = 10'(fill);
        t.known = known; t.result = 10'(res);
        return t;
    endfunction

    function automatic t_row random_row();
        t_row t;
        int sel, span;
        sel = $urandom_range(0, 99);
        t = mk(ramst_pkg::CMD_QUERY, $urandom, $urandom, $urandom, $urandom);
        span = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 40);
        t.lo = 10'($urandom_range(0, 1023));
        t.hi = 10'((t.lo + span > 1023) ? 1023 : t.lo + span);
        if ($urandom_range(0, 19) == 0) t.hi = 10'($urandom);
        if (sel < 30) t.cmd = ramst_pkg::CMD_LOAD;
        else if (sel < 55) t.cmd = ramst_pkg::CMD_ASSIGN;
        else if (sel < 97) t.cmd = ramst_pkg::CMD_QUERY;
        else t.cmd = CMD_UNKNOWN;
        return t;
    endfunction

    task automatic send(t_row t);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_command    <= t.cmd;
        i_leaf_index <= t.leaf;
        i_range_low  <= t.lo;
        i_range_high <= t.hi;
        i_fill_value <= t.fill;
        do @(posedge i_clk); while (busy);
        apply_command(t);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (minimum_queue.size() == 0) begin
                $display("%0t unexpected result: expected none actual %0d",
                         $time, o_range_minimum);
                fail_count++;
            end else begin
                logic [9:0] e;
                e = minimum_queue.pop_front();
                if (o_range_minimum !== e) begin
                    $display("%0t range_minimum mismatch: expected %0d actual %0d",
                             $time, e, o_range_minimum);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("range_assign_min_segment_tree_unit regression: fail");
            $finish;
        end
    end

    initial begin
        fail_count   = 0;
        idle_cycles  = 0;
        start        = 1'b0;
        i_command    = ramst_pkg::CMD_LOAD;
        i_leaf_index = '0;
        i_range_low  = '0;
        i_range_high = '0;
        i_fill_value = '0;
        i_rst_n      = 1'b0;
        for (int n = 1; n < 2 * LEAVES; n++) tree_min[n] = EMPTY;
        for (int n = 1; n < LEAVES; n++) begin
            mark_val[n] = '0;
            mark_on[n]  = 1'b0;
        end
        // reset tree, extremes, empty ranges, unknown command
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 0, 1023, 0, 1, 1023));
        rows.push_back(mk(ramst_pkg::CMD_LOAD,   0, 0, 0, 1023));
        rows.push_back(mk(ramst_pkg::CMD_LOAD, 1023, 0, 0, 0));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 1023, 1023, 0, 1, 0));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 0, 1023, 0, 1, 0));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 5, 4, 0, 1, 1023));
        rows.push_back(mk(ramst_pkg::CMD_ASSIGN, 0, 100, 50, 7));
        rows.push_back(mk(ramst_pkg::CMD_ASSIGN, 0, 0, 1023, 512));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 3, 900, 0, 1, 512));
        rows.push_back(mk(ramst_pkg::CMD_ASSIGN, 0, 10, 20, 341));
        rows.push_back(mk(ramst_pkg::CMD_LOAD,  15, 0, 0, 682));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 12, 18, 0));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 15, 15, 0, 1, 682));
        rows.push_back(mk(CMD_UNKNOWN, 15, 15, 15, 0));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 15, 15, 0, 1, 682));
        rows.push_back(mk(ramst_pkg::CMD_ASSIGN, 0, 0, 1023, 0));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 1023, 1023, 0, 1, 0));
        rows.push_back(mk(ramst_pkg::CMD_ASSIGN, 0, 511, 512, 1));
        rows.push_back(mk(ramst_pkg::CMD_QUERY,  0, 500, 600, 0));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[k]) send(rows[k]);
        for (int k = 0; k < 1650; k++) send(random_row());
        start <= 1'b0;
        while (minimum_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("range_assign_min_segment_tree_unit regression: pass");
        else
            $display("range_assign_min_segment_tree_unit regression: fail");
        $finish;
    end
endmodule
